// File: hw/rtl/pbef_pkg.sv
// ----------------------------------------------------------------------------
// pbef_pkg
// Shared types, constants and codes of the point box exclusion filter.
// ----------------------------------------------------------------------------
package pbef_pkg;

	localparam int MAX_BOXES_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int COORD_W  = 32;
	localparam int SIZE_W   = 31;
	localparam int KIND_W   = 3;
	localparam int ROW_W    = 2;
	localparam int PAD_W    = 20;
	localparam int TMO_W    = 16;
	localparam int AGE_W    = 16;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 1;
	localparam int HALF_W   = 32;
	localparam int Q_W      = 68;

	localparam logic [PAD_W-1:0] PADDING_RST = 20'd6554;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd500;
	localparam logic [AGE_W-1:0] AGE_MAX     = 16'hFFFF;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ROW   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POINT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_PADDING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ROW_W-1:0]   row;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_z;
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [COORD_W-1:0] shift_t;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic               keep;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [COORD_W-1:0] point_z;
		logic               cloud_end;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_in;   // capture input item
		logic       do_clear;
		logic       do_add;
		logic       do_row;
		logic       do_tick;
		logic       mul_start; // begin transform of row mul_row
		logic [1:0] mul_row;
		logic       mul_acc;   // accumulate product column
		logic [1:0] mul_col;
		logic       mul_fin;   // finish row: shift and translate
		logic       box_rd;    // issue box read
		logic       box_cmp;   // compare returned box
		logic       set_out;   // load output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              active;
		logic              hit;
		logic              out_busy;
	} dp_stat_t;

endpackage

// File: hw/rtl/pbef_if.sv
// ----------------------------------------------------------------------------
// pbef_in_if / pbef_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pbef_in_if;
	logic             valid;
	logic             ready;
	pbef_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbef_out_if;
	logic              valid;
	logic              ready;
	pbef_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pbef_ram.sv
// ----------------------------------------------------------------------------
// pbef_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbef_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/pbef_datapath.sv
// ----------------------------------------------------------------------------
// pbef_datapath
// Transform registers, serial multiply-accumulate, box table and compare.
// ----------------------------------------------------------------------------
module pbef_datapath #(
	parameter int MAX_BOXES = pbef_pkg::MAX_BOXES_DEF,
	parameter int FRAC_BITS = pbef_pkg::FRAC_BITS_DEF,
	localparam int ROT_W = FRAC_BITS + 2,
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
	localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pbef_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbef_pkg::CFG_W-1:0]        cfg_data,
	input  pbef_pkg::in_item_t                in_data,
	input  pbef_pkg::ctl_cmd_t                cmd,
	input  logic [CNT_W-1:0]                  box_idx,
	output logic [CNT_W-1:0]                  box_count,
	output pbef_pkg::dp_stat_t                stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pbef_pkg::out_item_t               out_data
);
	localparam int PROD_W = ROT_W + pbef_pkg::COORD_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = pbef_pkg::Q_W;
	localparam int RAM_W  = 3 * pbef_pkg::COORD_W + 3 * pbef_pkg::HALF_W;
	localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1) << FRAC_BITS;
	localparam logic signed [ROT_W-1:0] ROT_HI  = {1'b0, {(ROT_W-1){1'b1}}};
	localparam logic signed [ROT_W-1:0] ROT_LO  = {1'b1, {(ROT_W-1){1'b0}}};

	logic [pbef_pkg::PAD_W-1:0] padding_q;
	logic [pbef_pkg::TMO_W-1:0] timeout_q;
	logic [pbef_pkg::AGE_W-1:0] age_q;
	logic                       seen_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [ROT_W-1:0]    rot_q [9];
	logic signed [pbef_pkg::COORD_W-1:0] trans_q [3];
	pbef_pkg::in_item_t         item_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       prod_v_q;
	logic signed [Q_W-1:0]      qv_q [3];
	logic                       hit_q;
	logic                       out_v_q;
	pbef_pkg::out_item_t        out_q;
	logic [RAM_W-1:0]           wdata, rdata;
	logic [3:0]                 wsel;

	function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [31:0] v);
		if (v > 32'(ROT_HI)) return ROT_HI;
		if (v < 32'(ROT_LO)) return ROT_LO;
		return ROT_W'(v);
	endfunction

	function automatic logic [pbef_pkg::HALF_W-1:0] half_of(input logic [30:0] s,
			input logic [pbef_pkg::PAD_W-1:0] p);
		return 32'(s[30:1]) + 32'(p);
	endfunction

	assign wsel = 4'(item_q.row) * 4'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			padding_q <= pbef_pkg::PADDING_RST;
			timeout_q <= pbef_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbef_pkg::REG_PADDING: padding_q <= cfg_data[pbef_pkg::PAD_W-1:0];
				pbef_pkg::REG_TIMEOUT: timeout_q <= cfg_data[pbef_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q   <= '0;
			seen_q  <= 1'b0;
			count_q <= '0;
			for (int i = 0; i < 9; i++) begin
				rot_q[i] <= (i % 4 == 0) ? ROT_ONE : '0;
			end
			for (int i = 0; i < 3; i++) begin
				trans_q[i] <= '0;
			end
		end else begin
			if (cmd.do_clear) begin
				age_q   <= '0;
				seen_q  <= 1'b1;
				count_q <= '0;
			end
			if (cmd.do_add && count_q < CNT_W'(MAX_BOXES)) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.do_tick && age_q != pbef_pkg::AGE_MAX) begin
				age_q <= age_q + 16'd1;
			end
			if (cmd.do_row && item_q.row <= 2'd2) begin
				rot_q[wsel]         <= sat_rot(item_q.coord_x);
				rot_q[wsel + 4'd1]  <= sat_rot(item_q.coord_y);
				rot_q[wsel + 4'd2]  <= sat_rot(item_q.coord_z);
				trans_q[item_q.row] <= item_q.shift_t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= in_data;
		end
	end

	// one product per cycle, registered, then accumulated
	logic signed [pbef_pkg::COORD_W-1:0] mul_a;
	logic [3:0] rsel;
	always_comb begin
		rsel = 4'(cmd.mul_row) * 4'd3 + 4'(cmd.mul_col);
		case (cmd.mul_col)
			2'd0:    mul_a = item_q.coord_x;
			2'd1:    mul_a = item_q.coord_y;
			default: mul_a = item_q.coord_z;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_q <= 1'b0;
		end else begin
			prod_v_q <= cmd.mul_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_acc) begin
			prod_q <= rot_q[rsel] * mul_a;
		end
		if (cmd.mul_start) begin
			acc_q <= '0;
		end else if (prod_v_q) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.mul_fin) begin
			qv_q[cmd.mul_row] <= Q_W'(acc_q >>> FRAC_BITS) + Q_W'(trans_q[cmd.mul_row]);
		end
	end

	assign wdata = {item_q.coord_x, item_q.coord_y, item_q.coord_z,
		half_of(item_q.size_x, padding_q), half_of(item_q.size_y, padding_q),
		half_of(item_q.size_z, padding_q)};

	pbef_ram #(.WIDTH(RAM_W), .DEPTH(MAX_BOXES)) u_boxes (
		.clk  (clk),
		.we   (cmd.do_add && count_q < CNT_W'(MAX_BOXES)),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wdata),
		.raddr(box_idx[IDX_W-1:0]),
		.rdata(rdata)
	);

	logic in_box;
	always_comb begin
		logic signed [Q_W-1:0] d [3];
		logic [Q_W-1:0] ad [3];
		logic [pbef_pkg::HALF_W-1:0] h [3];
		logic signed [pbef_pkg::COORD_W-1:0] c [3];
		in_box = 1'b1;
		c[0] = rdata[RAM_W-1 -: 32];
		c[1] = rdata[RAM_W-33 -: 32];
		c[2] = rdata[RAM_W-65 -: 32];
		h[0] = rdata[95:64];
		h[1] = rdata[63:32];
		h[2] = rdata[31:0];
		for (int a = 0; a < 3; a++) begin
			d[a] = qv_q[a] - Q_W'(c[a]);
			ad[a] = d[a][Q_W-1] ? Q_W'(-d[a]) : Q_W'(d[a]);
			if (ad[a] > Q_W'(h[a])) in_box = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			hit_q <= 1'b0;
		end else if (cmd.box_cmp && in_box) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.set_out) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_out) begin
			out_q.keep      <= !hit_q;
			out_q.point_x   <= item_q.coord_x;
			out_q.point_y   <= item_q.coord_y;
			out_q.point_z   <= item_q.coord_z;
			out_q.cloud_end <= item_q.last;
		end
	end

	assign out_valid      = out_v_q;
	assign out_data       = out_q;
	assign box_count      = count_q;
	assign stat.kind      = item_q.kind;
	assign stat.active    = seen_q && count_q != '0 && age_q < timeout_q;
	assign stat.hit       = hit_q;
	assign stat.out_busy  = out_v_q && !out_ready;
endmodule

// File: hw/rtl/pbef_ctrl.sv
// ----------------------------------------------------------------------------
// pbef_ctrl
// Sequencer: decodes each item, steps the transform and walks the box table.
// ----------------------------------------------------------------------------
module pbef_ctrl #(
	parameter int MAX_BOXES = pbef_pkg::MAX_BOXES_DEF,
	localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pbef_pkg::dp_stat_t stat,
	input  logic [CNT_W-1:0]   box_count,
	output logic [CNT_W-1:0]   box_idx,
	output pbef_pkg::ctl_cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEC  = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_FIN  = 7'b0001000,
		S_RD   = 7'b0010000,
		S_CMP  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] row_q, row_d, col_q, col_d;
	logic [2:0] wait_q, wait_d;
	logic [CNT_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			wait_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			wait_q  <= wait_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		wait_d  = wait_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.mul_row = row_q;
		cmd.mul_col = col_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				case (stat.kind)
					pbef_pkg::KIND_CLEAR: cmd.do_clear = 1'b1;
					pbef_pkg::KIND_ADD:   cmd.do_add = 1'b1;
					pbef_pkg::KIND_ROW:   cmd.do_row = 1'b1;
					pbef_pkg::KIND_TICK:  cmd.do_tick = 1'b1;
					pbef_pkg::KIND_POINT: begin
						if (stat.active) begin
							cmd.mul_start = 1'b1;
							row_d = '0;
							col_d = '0;
							state_d = S_MUL;
						end else begin
							state_d = S_OUT;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				cmd.mul_acc = 1'b1;
				if (col_q == 2'd2) begin
					col_d = '0;
					wait_d = '0;
					state_d = S_FIN;
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			S_FIN: begin
				// wait for last product to be accumulated
				if (wait_q == 3'd1) begin
					cmd.mul_fin = 1'b1;
					if (row_q == 2'd2) begin
						idx_d = '0;
						state_d = S_RD;
					end else begin
						row_d = row_q + 2'd1;
						state_d = S_MUL;
					end
				end else begin
					wait_d = wait_q + 3'd1;
					if (wait_q == 3'd0) begin
						cmd.mul_start = 1'b0;
					end
				end
			end
			S_RD: begin
				cmd.box_rd = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.box_cmp = 1'b1;
				if (idx_q + CNT_W'(1) >= box_count) begin
					state_d = S_OUT;
				end else begin
					idx_d = idx_q + CNT_W'(1);
					state_d = S_RD;
				end
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.set_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_FIN && wait_q == 3'd1 && row_q != 2'd2) begin
			cmd.mul_start = 1'b1;
			cmd.mul_row = row_q;
		end
	end

	assign box_idx = idx_q;
endmodule

// File: hw/rtl/point_box_exclusion_filter_unit.sv
// ----------------------------------------------------------------------------
// point_box_exclusion_filter_unit
// Transforms points, flags those inside stored boxes (keep low); one item at a time.
// Non-point items are decoded only; a point with filtering off goes to output.
// Active point: 3 rows through the serial multiplier, then per box a RAM read
// and a compare, then the output register.
// arst_n clears control, counts, age and transform to identity; box RAM is not.
// ----------------------------------------------------------------------------
module point_box_exclusion_filter_unit #(
	parameter int MAX_BOXES = pbef_pkg::MAX_BOXES_DEF,
	parameter int FRAC_BITS = pbef_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbef_pkg::CFG_W-1:0]     cfg_data,
	pbef_in_if.sink                        in_ch,
	pbef_out_if.source                     out_ch
);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	pbef_pkg::ctl_cmd_t cmd;
	pbef_pkg::dp_stat_t stat;
	logic [CNT_W-1:0]   box_idx, box_count;

	// the unit row cycle: mul_start, 3 products, then finish
	pbef_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.box_count(box_count),
		.box_idx  (box_idx),
		.cmd      (cmd)
	);

	pbef_datapath #(.MAX_BOXES(MAX_BOXES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_ch.data),
		.cmd      (cmd),
		.box_idx  (box_idx),
		.box_count(box_count),
		.stat     (stat),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data (out_ch.data)
	);
endmodule

// File: hw/rtl/pbef_checker.sv
// ----------------------------------------------------------------------------
// pbef_port_checks
// Port-level checks of the filter unit.
// ----------------------------------------------------------------------------
module pbef_port_checks (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pbef_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while busy");

	a_out_needs_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised while idle");
endmodule

bind point_box_exclusion_filter_unit pbef_port_checks u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);
